>>> sv/uf_pkg.sv
`default_nettype none
package uf_pkg;
    localparam int MaxElements = 1024;
    localparam int IdxW = $clog2(MaxElements);
    localparam int CntW = $clog2(MaxElements + 1);
    localparam int RankW = 4;
    localparam logic [RankW-1:0] RankMax = 4'd15;

    localparam logic [1:0] ActMake  = 2'd0;
    localparam logic [1:0] ActFind  = 2'd1;
    localparam logic [1:0] ActUnion = 2'd2;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StMissing = 2'd1;
    localparam logic [1:0] StFull    = 2'd2;

    typedef enum logic [3:0] {
        t_idle_s,
        t_srch_s,
        t_srch_w_s,
        t_walk_s,
        t_walk_w_s,
        t_cmp_s,
        t_cmp_w_s,
        t_link_s,
        t_link_w_s,
        t_key_s,
        t_key_w_s,
        t_out_s
    } t_state;
endpackage
`default_nettype wire

>>> sv/uf_tables.sv
`default_nettype none
// Element tables: key, parent and rank memories, one read and one write port each.
module uf_tables (
    input  wire logic                    i_clk,
    input  wire logic [uf_pkg::IdxW-1:0] i_raddr,
    output logic [31:0]                  o_key,
    output logic [uf_pkg::IdxW-1:0]      o_parent,
    output logic [uf_pkg::RankW-1:0]     o_rank,
    input  wire logic [uf_pkg::IdxW-1:0] i_waddr,
    input  wire logic                    i_key_we,
    input  wire logic [31:0]             i_key_wd,
    input  wire logic                    i_par_we,
    input  wire logic [uf_pkg::IdxW-1:0] i_par_wd,
    input  wire logic                    i_rank_we,
    input  wire logic [uf_pkg::RankW-1:0] i_rank_wd
);
    import uf_pkg::*;
    logic [31:0]      r_keys  [MaxElements];
    logic [IdxW-1:0]  r_pars  [MaxElements];
    logic [RankW-1:0] r_ranks [MaxElements];

    always_ff @(posedge i_clk) begin
        if (i_key_we) r_keys[i_waddr] <= i_key_wd;
        if (i_par_we) r_pars[i_waddr] <= i_par_wd;
        if (i_rank_we) r_ranks[i_waddr] <= i_rank_wd;
        o_key    <= r_keys[i_raddr];
        o_parent <= r_pars[i_raddr];
        o_rank   <= r_ranks[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/union_find_engine.sv
`default_nettype none
// Make writes the tables on accept; find and union search the key table, then walk parent links to the root.
// A link of two distinct roots of equal rank takes an extra state to raise the rank of the new root.
// A missing key ends after a search over all n entries with status missing; action 3 gives no result.
// Throughput: one request at a time; s_axis_tready is low from accept until the result is taken.
// Every table read goes through the registered read port of the element tables, so each access has a wait state.
// Reset (synchronous, i_rst_n low) clears the entry count and control; tables are not cleared.
module union_find_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // action[1:0], key_a[33:2], key_b[65:34], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // root_key[31:0], status[33:32], zero pad
);
    import uf_pkg::*;

    t_state r_state, n_state;
    logic [1:0]       r_act;
    logic [31:0]      r_ka, r_kb;
    logic [CntW-1:0]  r_cnt;
    logic [IdxW-1:0]  r_ptr;     // read pointer for searches and walks
    logic [CntW-1:0]  r_scan;
    logic             r_second;  // union: working on key_b
    logic             r_compress; // find: second walk rewriting parents
    logic [IdxW-1:0]  r_a, r_ra, r_rb, r_win;
    logic [RankW-1:0] r_rka;
    logic [31:0]      r_okey;
    logic [1:0]       r_ost;
    logic             r_ovalid;

    logic [31:0]      mem_key;
    logic [IdxW-1:0]  mem_par;
    logic [RankW-1:0] mem_rank;
    logic [IdxW-1:0]  raddr, waddr;
    logic key_we, par_we, rank_we;
    logic [31:0] key_wd;
    logic [IdxW-1:0] par_wd;
    logic [RankW-1:0] rank_wd;

    uf_tables u_tab (
        .i_clk, .i_raddr(raddr), .o_key(mem_key), .o_parent(mem_par), .o_rank(mem_rank),
        .i_waddr(waddr), .i_key_we(key_we), .i_key_wd(key_wd), .i_par_we(par_we),
        .i_par_wd(par_wd), .i_rank_we(rank_we), .i_rank_wd(rank_wd)
    );

    wire logic [31:0] skey = r_second ? r_kb : r_ka;
    // bounded parent, as out-of-range links count as roots
    wire logic [IdxW-1:0] par_safe =
        ({1'b0, mem_par} < r_cnt) ? mem_par : r_ptr;
    wire logic is_root = (par_safe == r_ptr);

    assign s_axis_tready = (r_state == t_idle_s) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_ost, r_okey};
    wire logic take = s_axis_tvalid && s_axis_tready;
    wire logic [1:0] in_act = s_axis_tdata[1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_idle_s: if (take && in_act == ActMake) n_state = t_out_s;
                else if (take && (in_act == ActFind || in_act == ActUnion)) n_state = t_srch_s;
            t_srch_s: n_state = (r_scan >= r_cnt) ? t_out_s : t_srch_w_s;
            t_srch_w_s: n_state = t_srch_s;
            t_walk_s: n_state = t_walk_w_s;
            t_walk_w_s: n_state = t_walk_s;
            t_cmp_s: n_state = t_cmp_w_s;
            t_cmp_w_s: n_state = t_link_s;
            // distinct roots of equal rank below the limit go through link_w to raise the rank
            t_link_s: n_state = (r_ra != r_rb && r_rka == mem_rank && r_rka < RankMax) ?
                t_link_w_s : t_key_s;
            t_link_w_s: n_state = t_key_s;
            t_key_s: n_state = t_key_w_s;
            t_key_w_s: n_state = t_out_s;
            t_out_s: n_state = t_idle_s;
            default: n_state = t_idle_s;
        endcase
        // data-dependent exits
        if (r_state == t_srch_w_s && mem_key == skey) n_state = t_walk_s;
        if (r_state == t_walk_w_s && (is_root || r_compress && r_ptr == r_ra)) begin
            if (r_compress) n_state = t_key_s;
            else if (r_act == ActFind) n_state = t_walk_s;
            else if (!r_second) n_state = t_srch_s;
            else n_state = t_cmp_s;
        end
    end

    always_comb begin
        raddr = r_ptr;
        waddr = r_ptr;
        key_we = 1'b0; par_we = 1'b0; rank_we = 1'b0;
        key_wd = r_ka; par_wd = r_ra; rank_wd = '0;
        if (r_state == t_idle_s && take && in_act == ActMake && r_cnt < CntW'(MaxElements)) begin
            waddr = r_cnt[IdxW-1:0];
            key_we = 1'b1; par_we = 1'b1; rank_we = 1'b1;
            key_wd = s_axis_tdata[33:2]; par_wd = r_cnt[IdxW-1:0];
        end
        if (r_state == t_srch_s) raddr = r_scan[IdxW-1:0];
        if (r_state == t_walk_w_s && r_compress && r_ptr != r_ra) begin
            par_we = 1'b1;
        end
        if (r_state == t_cmp_s) raddr = r_rb;
        if (r_state == t_key_s) raddr = r_win;
        if (r_state == t_link_s && r_ra != r_rb) begin
            if (r_rka >= mem_rank) begin
                waddr = r_rb; par_we = 1'b1; par_wd = r_ra;
            end else begin
                waddr = r_ra; par_we = 1'b1; par_wd = r_rb;
            end
        end
        if (r_state == t_link_w_s) begin
            waddr = r_ra; rank_we = 1'b1; rank_wd = r_rka + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle_s;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == t_out_s) r_ovalid <= 1'b1;
            if (take && in_act == ActMake && r_cnt < CntW'(MaxElements))
                r_cnt <= r_cnt + 1'b1;
        end
        if (take) begin
            r_act <= in_act;
            r_ka <= s_axis_tdata[33:2];
            r_kb <= s_axis_tdata[65:34];
            r_scan <= '0; r_ptr <= '0;
            r_second <= 1'b0; r_compress <= 1'b0;
            if (in_act == ActMake) begin
                r_okey <= (r_cnt < CntW'(MaxElements)) ? s_axis_tdata[33:2] : 32'd0;
                r_ost  <= (r_cnt < CntW'(MaxElements)) ? StOk : StFull;
            end
        end
        unique case (r_state)
            t_srch_s: begin
                r_ptr <= r_scan[IdxW-1:0];
                r_scan <= r_scan + 1'b1;
                if (r_scan >= r_cnt) begin r_okey <= '0; r_ost <= StMissing; end
            end
            t_srch_w_s: if (mem_key == skey) begin
                r_a <= r_ptr; r_scan <= '0;
            end
            t_walk_w_s: begin
                if (is_root || (r_compress && r_ptr == r_ra)) begin
                    if (r_compress) r_win <= r_ra;
                    else if (r_act == ActFind) begin
                        r_ra <= r_ptr; r_compress <= 1'b1; r_ptr <= r_a;
                    end else if (!r_second) begin
                        r_ra <= r_ptr; r_second <= 1'b1;
                    end else r_rb <= r_ptr;
                end else r_ptr <= par_safe;
            end
            // keep reading rb so its rank is on the port in link
            t_cmp_s: r_ptr <= r_rb;
            t_link_s: begin
                if (r_ra == r_rb || r_rka >= mem_rank) r_win <= r_ra;
                else r_win <= r_rb;
            end
            t_key_w_s: begin r_okey <= mem_key; r_ost <= StOk; end
            default: ;
        endcase
        // rank of ra latched when its root is found
        if (r_state == t_walk_w_s && !r_compress && r_act == ActUnion && !r_second && is_root)
            r_rka <= mem_rank;
    end
endmodule
`default_nettype wire
